// File: hdl/ajb_pkg.sv
// shared types and constants for the adaptive jitter buffer
`timescale 1ns / 1ps
package ajb_pkg;
	localparam int MaxPackets = 32;
	localparam int SlotW = $clog2(MaxPackets);
	localparam int CountW = 6;

	localparam logic [1:0] FUNC_PUSH = 2'd0;
	localparam logic [1:0] FUNC_POP = 2'd1;
	localparam logic [1:0] FUNC_RESET = 2'd2;

	localparam logic [2:0] ST_NONE = 3'd0;
	localparam logic [2:0] ST_MISSING = 3'd1;
	localparam logic [2:0] ST_RELEASED = 3'd2;
	localparam logic [2:0] ST_STORED = 3'd3;
	localparam logic [2:0] ST_DROPPED = 3'd4;

	localparam logic [1:0] REG_INITIAL = 2'd0;
	localparam logic [1:0] REG_MIN = 2'd1;
	localparam logic [1:0] REG_MAX = 2'd2;
	localparam logic [1:0] REG_GAP = 2'd3;

	typedef struct packed {
		logic [1:0] func;
		logic [31:0] time_ms;
		logic [31:0] sequence_req;
		logic [15:0] payload_handle;
		logic [15:0] payload_length;
	} in_beat_t;

	typedef struct packed {
		logic [2:0] status;
		logic [31:0] rel_sequence;
		logic [15:0] out_handle;
		logic [15:0] out_length;
		logic [5:0] held_count;
		logic [9:0] target_delay;
	} out_beat_t;
endpackage

// File: hdl/adaptive_jitter_buffer.sv
// adaptive jitter buffer top level
`timescale 1ns / 1ps
// One beat in, one beat out. Every beat but a reset scans the 32-entry
// descriptor table one slot a cycle, and that scan sets the latency. A push
// then runs the PUSH1, JIT and PUSH2 states and, when stored, PUSH3 and EVICT;
// a pop runs POP1 and, unless it answers none there, POP2; an unknown function
// goes from the scan to DONE and a reset straight to DONE, which registers the
// result. in_ready is low while a beat is processed and while the result waits
// in the output register, so the next beat is taken at the earliest in the
// cycle after the result is.
module adaptive_jitter_buffer import ajb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input in_beat_t in_data,
	output logic out_valid,
	input logic out_ready,
	output out_beat_t out_item,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_wdata
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SCAN = 4'd1;
	localparam logic [3:0] S_PUSH1 = 4'd2;
	localparam logic [3:0] S_EVICT = 4'd3;
	localparam logic [3:0] S_PUSH2 = 4'd4;
	localparam logic [3:0] S_PUSH3 = 4'd5;
	localparam logic [3:0] S_POP1 = 4'd6;
	localparam logic [3:0] S_POP2 = 4'd7;
	localparam logic [3:0] S_DONE = 4'd8;
	localparam logic [3:0] S_JIT = 4'd9;

	logic [3:0] state_q;
	logic [9:0] init_q, min_q, max_q;
	logic [31:0] gap_q;
	logic [MaxPackets-1:0] valid_q;
	logic [31:0] seq_mem_q [MaxPackets];
	logic [31:0] arr_mem_q [MaxPackets];
	logic [15:0] hnd_mem_q [MaxPackets];
	logic [15:0] len_mem_q [MaxPackets];
	logic [31:0] exp_q, start_q, prev_q;
	logic awaiting_q, prebuf_q;
	logic [9:0] target_q;
	logic [23:0] jit_q;
	in_beat_t req_q;
	out_beat_t out_q;
	logic out_valid_q;
	logic [SlotW:0] idx_q;
	logic [CountW-1:0] cnt_q;
	logic found_q, lo_ok_q, free_ok_q;
	logic [SlotW-1:0] found_s_q, lo_q, free_q;
	logic [31:0] key_q;

	logic [SlotW-1:0] ix;
	logic [31:0] gap_diff, delta, dev_full;
	logic [15:0] dev;
	logic [32:0] hold;
	logic [17:0] cand_w;
	logic [9:0] cand;
	logic [21:0] needed_prod;
	logic [9:0] needed;

	assign ix = idx_q[SlotW-1:0];
	assign in_ready = (state_q == S_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_item = out_q;
	assign gap_diff = (req_q.sequence_req > exp_q) ? req_q.sequence_req - exp_q
		: exp_q - req_q.sequence_req;
	assign delta = req_q.time_ms - prev_q;
	assign dev_full = (delta > 32'd20) ? delta - 32'd20 : 32'd20 - delta;
	assign dev = (dev_full > 32'd65535) ? 16'hFFFF : dev_full[15:0];
	assign cand_w = 18'(jit_q[23:7]) + 18'd20;
	assign hold = {1'b0, req_q.time_ms} - {1'b0, arr_mem_q[found_q ? found_s_q : lo_q]};
	// target / 20 by reciprocal multiplication, exact for 10-bit targets
	assign needed_prod = 22'(target_q) * 22'd3277;
	always_comb begin
		cand = (cand_w > 18'(max_q)) ? max_q : cand_w[9:0];
		if (cand < min_q) cand = min_q;
		needed = (needed_prod[21:16] < 6'd2) ? 10'd2 : 10'(needed_prod[21:16]);
	end

	always_ff @(posedge clk) begin
		if (state_q == S_PUSH3) begin
			seq_mem_q[free_q] <= req_q.sequence_req;
			arr_mem_q[free_q] <= req_q.time_ms;
			hnd_mem_q[free_q] <= req_q.payload_handle;
			len_mem_q[free_q] <= req_q.payload_length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			init_q <= 10'd60;
			min_q <= 10'd20;
			max_q <= 10'd200;
			gap_q <= 32'd100;
			valid_q <= '0;
			exp_q <= '0;
			start_q <= '0;
			prev_q <= '0;
			awaiting_q <= 1'b1;
			prebuf_q <= 1'b1;
			target_q <= 10'd60;
			jit_q <= '0;
			out_valid_q <= 1'b0;
			out_q <= '0;
			req_q <= '0;
			idx_q <= '0;
			cnt_q <= '0;
			found_q <= 1'b0;
			lo_ok_q <= 1'b0;
			free_ok_q <= 1'b0;
			found_s_q <= '0;
			lo_q <= '0;
			free_q <= '0;
			key_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_INITIAL: init_q <= cfg_wdata[9:0];
					REG_MIN: min_q <= cfg_wdata[9:0];
					REG_MAX: max_q <= cfg_wdata[9:0];
					REG_GAP: gap_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						req_q <= in_data;
						out_q <= '0;
						idx_q <= '0;
						cnt_q <= '0;
						found_q <= 1'b0;
						lo_ok_q <= 1'b0;
						free_ok_q <= 1'b0;
						case (in_data.func)
							FUNC_PUSH: begin
								key_q <= in_data.sequence_req;
								state_q <= S_SCAN;
							end
							FUNC_POP: begin
								key_q <= exp_q;
								state_q <= S_SCAN;
							end
							FUNC_RESET: begin
								valid_q <= '0;
								exp_q <= '0;
								awaiting_q <= 1'b1;
								prebuf_q <= 1'b1;
								target_q <= init_q;
								start_q <= '0;
								prev_q <= '0;
								jit_q <= '0;
								state_q <= S_DONE;
							end
							default: begin
								key_q <= exp_q;
								state_q <= S_SCAN;
							end
						endcase
					end
				end
				S_SCAN: begin
					// count, find key, lowest, first free
					if (valid_q[ix]) begin
						cnt_q <= cnt_q + 1'b1;
						if (seq_mem_q[ix] == key_q && !found_q) begin
							found_q <= 1'b1;
							found_s_q <= ix;
						end
						if (!lo_ok_q || seq_mem_q[ix] < seq_mem_q[lo_q]) begin
							lo_ok_q <= 1'b1;
							lo_q <= ix;
						end
					end else if (!free_ok_q) begin
						free_ok_q <= 1'b1;
						free_q <= ix;
					end
					if (idx_q == (SlotW + 1)'(MaxPackets - 1)) begin
						if (req_q.func == FUNC_PUSH) state_q <= S_PUSH1;
						else if (req_q.func == FUNC_POP) state_q <= S_POP1;
						else state_q <= S_DONE;
					end
					idx_q <= idx_q + 1'b1;
				end
				S_PUSH1: begin
					if (awaiting_q) begin
						exp_q <= req_q.sequence_req;
						awaiting_q <= 1'b0;
						prebuf_q <= 1'b1;
						start_q <= req_q.time_ms;
						prev_q <= req_q.time_ms;
					end else if (cnt_q == '0 && gap_diff > gap_q) begin
						exp_q <= req_q.sequence_req;
						prebuf_q <= 1'b1;
						target_q <= init_q;
						start_q <= req_q.time_ms;
						prev_q <= req_q.time_ms;
						jit_q <= '0;
					end
					state_q <= S_JIT;
				end
				S_JIT: begin
					// jitter*243 plus dev*13<<8, scaled back by 8
					if (prev_q != '0 && req_q.time_ms > prev_q) begin
						jit_q <= 24'((32'(jit_q) * 32'd243 + ((32'(dev) * 32'd13) << 8)) >> 8);
					end
					prev_q <= req_q.time_ms;
					if (cnt_q >= CountW'(MaxPackets)) begin
						valid_q[lo_q] <= 1'b0;
						cnt_q <= cnt_q - 1'b1;
						if (!free_ok_q) begin
							free_ok_q <= 1'b1;
							free_q <= lo_q;
						end
						if (found_q && found_s_q == lo_q) found_q <= 1'b0;
					end
					state_q <= S_PUSH2;
				end
				S_PUSH2: begin
					if (cnt_q != '0 && req_q.sequence_req < exp_q) begin
						out_q.status <= ST_DROPPED;
						state_q <= S_DONE;
					end else begin
						if (found_q) free_q <= found_s_q;
						state_q <= S_PUSH3;
					end
				end
				S_PUSH3: begin
					if (!found_q) cnt_q <= cnt_q + 1'b1;
					valid_q[free_q] <= 1'b1;
					state_q <= S_EVICT;
				end
				S_EVICT: begin
					target_q <= 10'((13'(target_q) * 13'd7 + 13'(cand)) >> 3);
					out_q.status <= ST_STORED;
					state_q <= S_DONE;
				end
				S_POP1: begin
					state_q <= S_POP2;
					if (cnt_q == '0) begin
						state_q <= S_DONE;
					end else if (prebuf_q) begin
						if (cnt_q < CountW'(needed) &&
							$signed({1'b0, req_q.time_ms} - {1'b0, start_q}) <
							$signed({23'd0, target_q})) begin
							state_q <= S_DONE;
						end else begin
							prebuf_q <= 1'b0;
						end
					end
				end
				S_POP2: begin
					if (!found_q) begin
						if (lo_ok_q && seq_mem_q[lo_q] > exp_q &&
							($signed(hold) >= $signed({23'd0, target_q}) ||
							cnt_q >= CountW'(MaxPackets / 3))) begin
							exp_q <= exp_q + 1'b1;
							out_q.status <= ST_MISSING;
						end
					end else begin
						if (!($signed(hold) < $signed({23'd0, target_q}) &&
							cnt_q < CountW'(MaxPackets / 2))) begin
							out_q.status <= ST_RELEASED;
							out_q.rel_sequence <= seq_mem_q[found_s_q];
							out_q.out_handle <= hnd_mem_q[found_s_q];
							out_q.out_length <= len_mem_q[found_s_q];
							valid_q[found_s_q] <= 1'b0;
							cnt_q <= cnt_q - 1'b1;
							exp_q <= exp_q + 1'b1;
						end
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					out_q.held_count <= (req_q.func == FUNC_RESET) ? '0 : cnt_q;
					out_q.target_delay <= target_q;
					out_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: hdl/ajb_checker.sv
// port-level checks for the adaptive jitter buffer
`timescale 1ns / 1ps
module ajb_checker import ajb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input out_beat_t out_item
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item)) else $error("out hold");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("ready after accept");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.held_count <= 6'(MaxPackets)) else $error("count");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status != ST_RELEASED |-> out_item.rel_sequence == '0)
		else $error("payload");
endmodule

bind adaptive_jitter_buffer ajb_checker u_ajb_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
);
